### rtl/mvs_pkg.sv
// Shared types and constants for the mean / variance / std-dev block.
// No dependencies; imported by every file except mvs_ram and mvs_div.
`default_nettype none
package mvs_pkg;

   localparam int SAMPLE_W = 16;
   localparam int MEAN_W   = 24;
   localparam int VAR_W    = 38;
   localparam int SD_W     = 23;
   localparam int COUNT_W  = 11;
   localparam int PROD_W   = 48;

   // Commands from the controller to the datapath
   typedef struct packed {
      logic accept;      // store the request sample or mark overflow
      logic clr_set;     // result taken: start a new set
      logic rd_rst;      // rewind the read pointer and clear accumulators
      logic rd_go;       // issue one store read and advance
      logic div_start;   // launch the shared divider
      logic div_var;     // divider operands: 0 mean, 1 variance
      logic mean_take;   // capture the floored mean
      logic var_take;    // capture the saturated variance
      logic sqrt_start;  // launch the square root unit
      logic out_load;    // load the result register
   } mvs_cmd_type;

   // Status from the datapath to the controller
   typedef struct packed {
      logic rd_last;     // read pointer is on the last stored sample
      logic pipe_busy;   // reads still in flight through the pass pipeline
      logic div_done;
      logic sqrt_done;
   } mvs_stat_type;

endpackage
`default_nettype wire

### rtl/mvs_if.sv
// Valid/ready channel interfaces for sample requests and statistic results.
// Depends on mvs_pkg for field widths.
`default_nettype none
interface mvs_req_if;
   import mvs_pkg::*;
   logic                       valid;
   logic                       ready;
   logic signed [SAMPLE_W-1:0] sample;
   logic                       last;
   modport source (output valid, sample, last, input ready);
   modport sink   (input valid, sample, last, output ready);
endinterface

interface mvs_rsp_if;
   import mvs_pkg::*;
   logic                     valid;
   logic                     ready;
   logic signed [MEAN_W-1:0] mean;
   logic [VAR_W-1:0]         variance;
   logic [SD_W-1:0]          std_dev;
   logic [COUNT_W-1:0]       count;
   logic                     overflow;
   modport source (output valid, mean, variance, std_dev, count, overflow, input ready);
   modport sink   (input valid, mean, variance, std_dev, count, overflow, output ready);
endinterface
`default_nettype wire

### rtl/mvs_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none
module mvs_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 1024
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] waddr,
   input  wire logic [WIDTH-1:0]         wdata,
   input  wire logic [$clog2(DEPTH)-1:0] raddr,
   output logic      [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem [DEPTH];

   // Write port and registered read port
   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata <= mem[raddr];
   end
endmodule
`default_nettype wire

### rtl/mvs_div.sv
// Restoring unsigned divider, one quotient bit per cycle.
// No package dependencies.
`default_nettype none
module mvs_div #(
   parameter int DW = 50,
   parameter int CW = 11
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          start,
   input  wire logic [DW-1:0] dividend,
   input  wire logic [CW-1:0] divisor,
   output logic      [DW-1:0] quo,
   output logic      [CW-1:0] rem,
   output logic               done
);
   localparam int NW = $clog2(DW + 1);

   logic [DW-1:0] quo_ff, quo_in;
   logic [CW-1:0] rem_ff, rem_in;
   logic [CW-1:0] dvs_ff, dvs_in;
   logic [NW-1:0] cnt_ff, cnt_in;
   logic          busy_ff, busy_in;
   logic          done_ff, done_in;
   logic [CW:0]   trial;

   // One shift-subtract step per cycle
   always_comb begin
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      trial   = {rem_ff, quo_ff[DW-1]};
      if (start) begin
         quo_in  = dividend;
         rem_in  = '0;
         dvs_in  = divisor;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (trial >= {1'b0, dvs_ff}) begin
            rem_in = CW'(trial - {1'b0, dvs_ff});
            quo_in = {quo_ff[DW-2:0], 1'b1};
         end else begin
            rem_in = trial[CW-1:0];
            quo_in = {quo_ff[DW-2:0], 1'b0};
         end
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == NW'(DW - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
      cnt_ff <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign quo  = quo_ff;
   assign rem  = rem_ff;
   assign done = done_ff;
endmodule
`default_nettype wire

### rtl/mvs_sqrt.sv
// Bit-pair integer square root, one result bit per cycle.
// Depends on mvs_pkg for the result width.
`default_nettype none
module mvs_sqrt (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         start,
   input  wire logic [2*mvs_pkg::SD_W-1:0]   radicand,
   output logic      [mvs_pkg::SD_W-1:0]     root,
   output logic                              done
);
   import mvs_pkg::*;
   localparam int RW = 2 * SD_W;
   localparam int NW = $clog2(SD_W + 1);

   logic [RW-1:0]   rad_ff, rad_in;
   logic [SD_W+1:0] rem_ff, rem_in;
   logic [SD_W-1:0] root_ff, root_in;
   logic [NW-1:0]   cnt_ff, cnt_in;
   logic            busy_ff, busy_in;
   logic            done_ff, done_in;
   logic [SD_W+3:0] rem_sh;
   logic [SD_W+3:0] trial;

   // Bring down two radicand bits, try root*4+1
   always_comb begin
      rad_in  = rad_ff;
      rem_in  = rem_ff;
      root_in = root_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      rem_sh  = {rem_ff, rad_ff[RW-1:RW-2]};
      trial   = {2'b00, root_ff, 2'b01};
      if (start) begin
         rad_in  = radicand;
         rem_in  = '0;
         root_in = '0;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rad_in = {rad_ff[RW-3:0], 2'b00};
         if (rem_sh >= trial) begin
            rem_in  = (SD_W + 2)'(rem_sh - trial);
            root_in = {root_ff[SD_W-2:0], 1'b1};
         end else begin
            rem_in  = rem_sh[SD_W+1:0];
            root_in = {root_ff[SD_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == NW'(SD_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      rad_ff  <= rad_in;
      rem_ff  <= rem_in;
      root_ff <= root_in;
      cnt_ff  <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign root = root_ff;
   assign done = done_ff;
endmodule
`default_nettype wire

### rtl/mvs_dp.sv
// Datapath: sample store, pass pipeline, shared divider, square root, result register.
// Depends on mvs_pkg, mvs_ram, mvs_div and mvs_sqrt.
`default_nettype none
module mvs_dp #(
   parameter int DEPTH = 1024
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire mvs_pkg::mvs_cmd_type              cmd,
   output mvs_pkg::mvs_stat_type                  stat,
   input  wire logic signed [mvs_pkg::SAMPLE_W-1:0] sample,
   output logic signed [mvs_pkg::MEAN_W-1:0]      mean,
   output logic [mvs_pkg::VAR_W-1:0]              variance,
   output logic [mvs_pkg::SD_W-1:0]               std_dev,
   output logic [mvs_pkg::COUNT_W-1:0]            count,
   output logic                                   overflow
);
   import mvs_pkg::*;
   localparam int AW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);
   localparam int SW = SAMPLE_W + 1 + AW;
   localparam int DW = 40 + AW;
   localparam int QW = DW + 8;

   logic [CW-1:0]             cnt_ff, rd_ff;
   logic                      ovf_ff, v1_ff, v2_ff;
   logic signed [SW-1:0]      sum_ff;
   logic [PROD_W-1:0]         prod_ff;
   logic [QW-1:0]             sq_ff;
   logic signed [MEAN_W-1:0]  mean_ff;
   logic [VAR_W-1:0]          var_ff;
   logic [SAMPLE_W-1:0]       q;
   logic                      full;
   logic signed [MEAN_W:0]    dev;
   logic [MEAN_W-1:0]         dev_abs;
   logic [SW-1:0]             sum_abs;
   logic [DW-1:0]             dvd, quo;
   logic [CW-1:0]             rem;
   logic [DW-1:0]             mean_q;
   logic [SD_W-1:0]           root;
   logic [CW+COUNT_W-1:0]     cnt_ext;
   logic                      div_done;
   logic                      sqrt_done;

   assign full = (cnt_ff == CW'(DEPTH));

   mvs_ram #(.WIDTH(SAMPLE_W), .DEPTH(DEPTH)) u_store (
      .clock (clock),
      .we    (cmd.accept & ~full),
      .waddr (cnt_ff[AW-1:0]),
      .wdata (sample),
      .raddr (rd_ff[AW-1:0]),
      .rdata (q)
   );

   // Deviation of the read sample from the mean, at scale 256
   always_comb begin
      dev     = {q[SAMPLE_W-1], q, 8'b0} - {mean_ff[MEAN_W-1], mean_ff};
      dev_abs = dev[MEAN_W] ? MEAN_W'(-dev) : dev[MEAN_W-1:0];
      sum_abs = sum_ff[SW-1] ? SW'(-sum_ff) : sum_ff;
      dvd     = cmd.div_var ? sq_ff[QW-1:8] : {15'b0, sum_abs, 8'b0};
      mean_q  = ~sum_ff[SW-1] ? quo : ((rem != '0) ? ~quo : DW'(-quo));
      cnt_ext = {{COUNT_W{1'b0}}, cnt_ff};
   end

   mvs_div #(.DW(DW), .CW(CW)) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend (dvd),
      .divisor  (cnt_ff),
      .quo      (quo),
      .rem      (rem),
      .done     (div_done)
   );

   mvs_sqrt u_sqrt (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.sqrt_start),
      .radicand ({var_ff, 8'b0}),
      .root     (root),
      .done     (sqrt_done)
   );

   // Set bookkeeping and read pipeline control
   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
         ovf_ff <= 1'b0;
         rd_ff  <= '0;
         v1_ff  <= 1'b0;
         v2_ff  <= 1'b0;
      end else begin
         if (cmd.clr_set) begin
            cnt_ff <= '0;
            ovf_ff <= 1'b0;
         end else if (cmd.accept) begin
            if (full) begin
               ovf_ff <= 1'b1;
            end else begin
               cnt_ff <= cnt_ff + 1'b1;
            end
         end
         if (cmd.rd_rst) begin
            rd_ff <= '0;
         end else if (cmd.rd_go) begin
            rd_ff <= rd_ff + 1'b1;
         end
         v1_ff <= cmd.rd_go;
         v2_ff <= v1_ff;
      end
   end

   // Accumulate both passes; square, then add in the next cycle
   always_ff @(posedge clock) begin
      if (cmd.rd_rst) begin
         sum_ff <= '0;
         sq_ff  <= '0;
      end else begin
         if (v1_ff) begin
            sum_ff <= sum_ff + {{(SW-SAMPLE_W){q[SAMPLE_W-1]}}, q};
         end
         if (v2_ff) begin
            sq_ff <= sq_ff + {{(QW-PROD_W){1'b0}}, prod_ff};
         end
      end
      if (v1_ff) begin
         prod_ff <= dev_abs * dev_abs;
      end
      if (cmd.mean_take) begin
         mean_ff <= mean_q[MEAN_W-1:0];
      end
      if (cmd.var_take) begin
         var_ff <= (|quo[DW-1:VAR_W]) ? '1 : quo[VAR_W-1:0];
      end
      if (cmd.out_load) begin
         mean     <= mean_ff;
         variance <= var_ff;
         std_dev  <= root;
         count    <= cnt_ext[COUNT_W-1:0];
         overflow <= ovf_ff;
      end
   end

   // Status in field order: rd_last, pipe_busy, div_done, sqrt_done
   assign stat = {(rd_ff == CW'(cnt_ff - 1'b1)), (v1_ff | v2_ff), div_done, sqrt_done};
endmodule
`default_nettype wire

### rtl/mvs_ctrl.sv
// Controller state machine: load, mean pass, deviation pass, divide, root, deliver.
// Depends on mvs_pkg.
`default_nettype none
module mvs_ctrl (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   input  wire logic                  req_last,
   output logic                       req_ready,
   output logic                       rsp_valid,
   input  wire logic                  rsp_ready,
   output mvs_pkg::mvs_cmd_type       cmd,
   input  wire mvs_pkg::mvs_stat_type stat
);
   import mvs_pkg::*;

   typedef enum logic [9:0] {
      ST_LOAD     = 10'b0000000001,
      ST_SUM      = 10'b0000000010,
      ST_SUM_WAIT = 10'b0000000100,
      ST_MEAN_DIV = 10'b0000001000,
      ST_SQ       = 10'b0000010000,
      ST_SQ_WAIT  = 10'b0000100000,
      ST_VAR_DIV  = 10'b0001000000,
      ST_ROOT_GO  = 10'b0010000000,
      ST_ROOT     = 10'b0100000000,
      ST_DONE     = 10'b1000000000
   } state_type;

   state_type state_ff, state_in;

   // Next state and commands
   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      rsp_valid = 1'b0;
      unique case (state_ff)
         ST_LOAD: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.accept = 1'b1;
               if (req_last) begin
                  cmd.rd_rst = 1'b1;
                  state_in   = ST_SUM;
               end
            end
         end
         ST_SUM: begin
            cmd.rd_go = 1'b1;
            if (stat.rd_last) begin
               state_in = ST_SUM_WAIT;
            end
         end
         ST_SUM_WAIT: begin
            if (!stat.pipe_busy) begin
               cmd.div_start = 1'b1;
               state_in      = ST_MEAN_DIV;
            end
         end
         ST_MEAN_DIV: begin
            if (stat.div_done) begin
               cmd.mean_take = 1'b1;
               cmd.rd_rst    = 1'b1;
               state_in      = ST_SQ;
            end
         end
         ST_SQ: begin
            cmd.rd_go = 1'b1;
            if (stat.rd_last) begin
               state_in = ST_SQ_WAIT;
            end
         end
         ST_SQ_WAIT: begin
            cmd.div_var = 1'b1;
            if (!stat.pipe_busy) begin
               cmd.div_start = 1'b1;
               state_in      = ST_VAR_DIV;
            end
         end
         ST_VAR_DIV: begin
            if (stat.div_done) begin
               cmd.var_take = 1'b1;
               state_in     = ST_ROOT_GO;
            end
         end
         ST_ROOT_GO: begin
            cmd.sqrt_start = 1'b1;
            state_in       = ST_ROOT;
         end
         ST_ROOT: begin
            if (stat.sqrt_done) begin
               cmd.out_load = 1'b1;
               state_in     = ST_DONE;
            end
         end
         ST_DONE: begin
            rsp_valid = 1'b1;
            if (rsp_ready) begin
               cmd.clr_set = 1'b1;
               state_in    = ST_LOAD;
            end
         end
         default: begin
            state_in = ST_LOAD;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_LOAD;
      end else begin
         state_ff <= state_in;
      end
   end
endmodule
`default_nettype wire

### rtl/mean_variance_stddev.sv
// Top level: population mean, variance and standard deviation of a sample set.
// Depends on mvs_pkg, mvs_if, mvs_ctrl and mvs_dp.
//
//   channel   direction  handshake     payload
//   req_chan  in         valid/ready   sample, last
//   rsp_chan  out        valid/ready   mean, variance, std_dev, count, overflow
//
// Samples load one per cycle. After the last one, a result is computed by the two
// read passes over the single-read sample store, the bit-serial divider (used
// twice) and the 23-step square root. No request is taken from the last sample
// until the result is taken. Synchronous reset clears the set; the store is not
// cleared.
`default_nettype none
module mean_variance_stddev #(
   parameter int DEPTH = 1024
) (
   input wire logic clock,
   input wire logic reset,
   mvs_req_if.sink   req_chan,
   mvs_rsp_if.source rsp_chan
);
   import mvs_pkg::*;

   mvs_cmd_type  cmd;
   mvs_stat_type stat;

   mvs_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_last  (req_chan.last),
      .req_ready (req_chan.ready),
      .rsp_valid (rsp_chan.valid),
      .rsp_ready (rsp_chan.ready),
      .cmd       (cmd),
      .stat      (stat)
   );

   mvs_dp #(.DEPTH(DEPTH)) u_dp (
      .clock    (clock),
      .reset    (reset),
      .cmd      (cmd),
      .stat     (stat),
      .sample   (req_chan.sample),
      .mean     (rsp_chan.mean),
      .variance (rsp_chan.variance),
      .std_dev  (rsp_chan.std_dev),
      .count    (rsp_chan.count),
      .overflow (rsp_chan.overflow)
   );

   // Loading and delivering never overlap
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      !(req_chan.ready && rsp_chan.valid))
      else $error("request taken while a result is pending");

   // A closing request stops intake
   a_last_stops: assert property (@(posedge clock) disable iff (reset)
      (req_chan.valid && req_chan.ready && req_chan.last) |=> !req_chan.ready)
      else $error("intake continued after the last sample");

   // A delivered result reopens intake
   a_reopen: assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && rsp_chan.ready) |=> req_chan.ready)
      else $error("intake not reopened after a result");
endmodule
`default_nettype wire

### tb/sv/mean_variance_stddev_chk.sv
// Checker for mean_variance_stddev: watches the request and result channels,
// predicts each result of a closed sample set, and compares field by field.
// Depends on mvs_pkg and the mvs_req_if / mvs_rsp_if interfaces.
`default_nettype none
module mean_variance_stddev_chk #(
   parameter int DEPTH = 1024
) (
   input  wire logic clock,
   input  wire logic reset,
   mvs_req_if.sink   req_mon,
   mvs_rsp_if.sink   rsp_mon,
   output int        fail_count,
   output int        stats_pending
);
   timeunit 1ns;
   timeprecision 1ps;
   import mvs_pkg::*;

   typedef struct {
      logic signed [MEAN_W-1:0] mean;
      logic [VAR_W-1:0]         variance;
      logic [SD_W-1:0]          std_dev;
      logic [COUNT_W-1:0]       count;
      logic                     overflow;
   } stats_type;

   stats_type   stats_q[$];
   shortint     set_samples[$];
   bit          set_dropped;

   // Bitwise integer square root
   function automatic longint unsigned isqrt(longint unsigned v);
      longint unsigned root;
      longint unsigned b;
      root = 0;
      b = 64'd1 << 62;
      while (b > v) b >>= 2;
      while (b != 0) begin
         if (v >= root + b) begin
            v -= root + b;
            root = (root >> 1) + b;
         end else begin
            root >>= 1;
         end
         b >>= 2;
      end
      return root;
   endfunction

   // Two-pass statistics over the closed set
   function automatic stats_type set_stats();
      stats_type s;
      longint n, total, scaled, m, d;
      longint unsigned sq, v, sd;
      n = set_samples.size();
      total = 0;
      sq = 0;
      foreach (set_samples[i]) total += set_samples[i];
      scaled = total * 256;
      m = scaled / n;
      if (scaled % n < 0) m -= 1;
      foreach (set_samples[i]) begin
         d = longint'(set_samples[i]) * 256 - m;
         if (d < 0) d = -d;
         sq += longint'(unsigned'(d)) * longint'(unsigned'(d));
      end
      v = sq / (longint'(unsigned'(n)) * 256);
      if (v > (64'd1 << VAR_W) - 1) v = (64'd1 << VAR_W) - 1;
      sd = isqrt(v * 256);
      if (sd > (64'd1 << SD_W) - 1) sd = (64'd1 << SD_W) - 1;
      s.mean     = m[MEAN_W-1:0];
      s.variance = v[VAR_W-1:0];
      s.std_dev  = sd[SD_W-1:0];
      s.count    = n[COUNT_W-1:0];
      s.overflow = set_dropped;
      return s;
   endfunction

   task automatic report(input string what, input longint got, input longint want);
      $display("MISMATCH %s: got %0d want %0d at %0t", what, got, want, $realtime);
      fail_count++;
   endtask

   initial begin
      fail_count = 0;
      stats_pending = 0;
      set_dropped = 0;
   end

   always @(posedge clock) begin
      stats_type w;
      if (reset) begin
         set_samples.delete();
         set_dropped = 0;
      end else begin
         // Record each accepted request, close the set on last
         if (req_mon.valid && req_mon.ready) begin
            if (set_samples.size() < DEPTH) set_samples.push_back(req_mon.sample);
            else set_dropped = 1;
            if (req_mon.last) begin
               stats_q.push_back(set_stats());
               set_samples.delete();
               set_dropped = 0;
            end
         end
         // Compare each taken result with the oldest prediction
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (stats_q.size() == 0) begin
               report("unexpected result", 1, 0);
            end else begin
               w = stats_q.pop_front();
               if (rsp_mon.mean !== w.mean) report("mean", rsp_mon.mean, w.mean);
               if (rsp_mon.variance !== w.variance)
                  report("variance", rsp_mon.variance, w.variance);
               if (rsp_mon.std_dev !== w.std_dev)
                  report("std_dev", rsp_mon.std_dev, w.std_dev);
               if (rsp_mon.count !== w.count) report("count", rsp_mon.count, w.count);
               if (rsp_mon.overflow !== w.overflow)
                  report("overflow", rsp_mon.overflow, w.overflow);
            end
         end
      end
      stats_pending = stats_q.size();
   end
endmodule
`default_nettype wire

### tb/sv/mean_variance_stddev_tb.sv
// Testbench top for mean_variance_stddev: drives sample requests in bursts,
// stalls the result side, and gives the verdict. Depends on mvs_pkg, mvs_if,
// the block and mean_variance_stddev_chk.
`default_nettype none
module mean_variance_stddev_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import mvs_pkg::*;

   localparam int DEPTH     = 1024;
   localparam int N_ITEMS   = 1700;
   localparam int MAX_CYCLE = 4000000;

   logic clock = 0;
   logic reset = 1;
   int   fail_count;
   int   stats_pending;
   int   cycle_count = 0;
   bit   long_hold = 0;
   bit   stim_done = 0;

   mvs_req_if req_chan ();
   mvs_rsp_if rsp_chan ();

   mean_variance_stddev #(.DEPTH(DEPTH)) u_top (
      .clock(clock), .reset(reset), .req_chan(req_chan), .rsp_chan(rsp_chan));

   mean_variance_stddev_chk #(.DEPTH(DEPTH)) u_chk (
      .clock(clock), .reset(reset), .req_mon(req_chan), .rsp_mon(rsp_chan),
      .fail_count(fail_count), .stats_pending(stats_pending));

   always #1 clock = ~clock;

   // Abort on runaway
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > MAX_CYCLE) begin
         $display("Test completed with failures");
         $finish;
      end
   end

   // Receiver stall pattern; long hold-off while long_hold is set
   initial begin
      int k;
      rsp_chan.ready = 0;
      k = 0;
      forever begin
         @(negedge clock);
         k++;
         if (long_hold) rsp_chan.ready <= 0;
         else if (k % 64 < 20) rsp_chan.ready <= 1;
         else rsp_chan.ready <= ($urandom_range(0, 3) != 0);
      end
   end

   // Send one request and hold until taken
   task automatic send_sample(input logic signed [SAMPLE_W-1:0] s, input logic l);
      req_chan.valid  <= 1;
      req_chan.sample <= s;
      req_chan.last   <= l;
      do @(posedge clock); while (!req_chan.ready);
      @(negedge clock);
   endtask

   task automatic gap(input int n);
      if (n > 0) begin
         req_chan.valid <= 0;
         repeat (n) @(negedge clock);
      end
   endtask

   function automatic logic signed [SAMPLE_W-1:0] rand_sample();
      case ($urandom_range(0, 5))
         0: return 16'sh7FFF;
         1: return 16'sh8000;
         2: return SAMPLE_W'($urandom_range(0, 15)) - SAMPLE_W'(8);
         default: return SAMPLE_W'($urandom);
      endcase
   endfunction

   initial begin
      int sent, len, burst, hold;
      req_chan.valid = 0;
      req_chan.sample = 0;
      req_chan.last = 0;
      hold = 0;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 0;
      @(negedge clock);

      // Directed: single extremes, tiny sets, mixed extremes
      send_sample(16'sh7FFF, 1);
      send_sample(16'sh8000, 1);
      send_sample(16'sh0000, 1);
      send_sample(-16'sd1, 1);
      send_sample(16'sh8000, 0);
      send_sample(16'sh7FFF, 1);
      send_sample(-16'sd1, 0);
      send_sample(16'sd0, 0);
      send_sample(16'sd0, 1);
      send_sample(16'sd5, 0);
      send_sample(-16'sd3, 0);
      send_sample(16'sh5555, 0);
      send_sample(16'shAAAA, 1);
      sent = 13;

      // Store-full set: DEPTH+6 alternating extremes, last six dropped
      for (int i = 0; i < DEPTH + 6; i++)
         send_sample(i[0] ? 16'sh7FFF : 16'sh8000, i == DEPTH + 5);
      sent += DEPTH + 6;

      // Random sets in bursts; most sets short so results are plentiful
      burst = $urandom_range(1, 20);
      while (sent < N_ITEMS) begin
         len = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 200) : $urandom_range(1, 12);
         for (int i = 0; i < len; i++) begin
            send_sample(rand_sample(), i == len - 1);
            sent++;
            if (--burst == 0) begin
               burst = $urandom_range(1, 20);
               gap($urandom_range(0, 1) ? 0 : $urandom_range(1, 6));
            end
         end
         // Pressure: hold off results while requests keep coming
         if (sent > N_ITEMS / 2 && hold == 0) begin
            hold = 1;
            long_hold = 1;
            fork
               begin
                  repeat (3000) @(negedge clock);
                  long_hold = 0;
               end
            join_none
         end
      end
      req_chan.valid <= 0;

      // Drain, then allow the block's tail latency
      while (stats_pending != 0) @(posedge clock);
      repeat (2 * DEPTH + 200) @(posedge clock);
      if (fail_count == 0 && stats_pending == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end
endmodule
`default_nettype wire
